// ===== rtl/core/ttc_pkg.sv =====
// Shared types and constants of the text console.
package ttc_pkg;

	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int LOC_W  = 11;
	localparam int IDX_W  = 11;
	localparam int MOD6_W = 3;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_MIN  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DEL     = 8'h7F;
	localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF      = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

	localparam int TAB_STEP = 8;
	localparam int VT_STEP  = 6;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_EXEC,
		ST_SCRL_SET,
		ST_COPY,
		ST_LOC,
		ST_FINISH
	} ttc_state_t;

endpackage

// ===== rtl/core/ttc_channels.sv =====
// Request and result channel interfaces of the text console.
interface ttc_cmd_if;
	import ttc_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;
	modport source (output valid, operation, char_code, cell_index, input ready);
	modport sink (input valid, operation, char_code, cell_index, output ready);
endinterface

interface ttc_rsp_if;
	import ttc_pkg::*;
	logic              valid;
	logic              ready;
	logic [LOC_W-1:0]  cursor_location;
	logic [CELL_W-1:0] cell_value;
	logic [CHAR_W-1:0] echoed_char;
	modport source (output valid, cursor_location, cell_value, echoed_char, input ready);
	modport sink (input valid, cursor_location, cell_value, echoed_char, output ready);
endinterface

// ===== rtl/core/ttc_screen_ram.sv =====
// Screen cell memory with one write port and one registered read port.
module ttc_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ttc_pkg::CELL_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [ttc_pkg::CELL_W-1:0] rdata
);
	import ttc_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/text_console_teletype.sv =====
// Top level of the text console: cursor sequencer, scroll engine and screen memory.
//
// The console keeps a COLUMNS x ROWS screen of 16-bit cells in a single-port-write
// memory and handles one request at a time. A read request passes through the EXEC
// and FINISH states, and a put of a printable or control character through EXEC, LOC
// and FINISH. A form feed, and a put that scrolls the screen, sweep the whole memory
// one cell per cycle, paced by the memory's single write port. After reset the memory
// is cleared to blank cells with attribute 7, during which no request is accepted;
// attribute writes are taken at any time.
module text_console_teletype #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ttc_pkg::ATTR_W-1:0] cfg_data,
	ttc_cmd_if.sink                    cmd,
	ttc_rsp_if.source                  rsp
);
	import ttc_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS + TAB_STEP);
	localparam int ROW_W = $clog2(ROWS + VT_STEP + 1);
	localparam logic [MOD6_W-1:0] LAST_MOD6 = MOD6_W'((ROWS - 1) % VT_STEP);

	function automatic logic [MOD6_W-1:0] mod6_inc(input logic [MOD6_W-1:0] m);
		return (m == MOD6_W'(VT_STEP - 1)) ? '0 : MOD6_W'(m + 1'b1);
	endfunction

	ttc_state_t state_q, state_d;

	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [MOD6_W-1:0] m6_q;
	logic [AW-1:0]     loc_q;
	logic [AW-1:0]     cnt_q;
	logic              boot_q;
	logic              wr_pend_s1;
	logic              out_valid_q;

	logic              op_q;
	logic [CHAR_W-1:0] char_q;
	logic              rd_ok_q;
	logic [CELL_W-1:0] cell_q;
	logic [MOD6_W-1:0] excess_q;
	logic [AW-1:0]     off_q;
	logic [AW-1:0]     last_q;
	logic [AW-1:0]     wr_addr_s1;
	logic [LOC_W-1:0]  out_loc_q;
	logic [CELL_W-1:0] out_cell_q;
	logic [CHAR_W-1:0] out_echo_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic [COL_W-1:0]  col_a, col_f;
	logic [ROW_W-1:0]  row_a, row_f;
	logic [MOD6_W-1:0] m_a, m_f;
	logic              exec_we;
	logic [AW-1:0]     exec_addr;
	logic [CELL_W-1:0] exec_data;
	logic              is_ff;
	logic              scroll_need;
	logic [MOD6_W-1:0] excess_f;
	logic [CELL_W-1:0] blank;
	logic              cmd_acc;
	logic              out_load;
	logic              fill_last;

	assign blank     = {(boot_q ? ATTR_RESET : attr_q), BLANK_CHAR};
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);
	assign fill_last = !wr_pend_s1 && (cnt_q == AW'(CELLS - 1));

	// Cursor motion for the latched character, then the column wrap.
	always_comb begin
		col_a     = col_q;
		row_a     = row_q;
		m_a       = m6_q;
		exec_we   = 1'b0;
		exec_addr = loc_q;
		exec_data = blank;
		is_ff     = 1'b0;
		unique case (char_q)
			CH_BS: begin
				if (col_q != '0) begin
					col_a     = COL_W'(col_q - 1'b1);
					exec_we   = 1'b1;
					exec_addr = AW'(loc_q - 1'b1);
				end
			end
			CH_TAB: begin
				col_a = COL_W'((col_q | COL_W'(TAB_STEP - 1)) + 1'b1);
			end
			CH_LF: begin
				col_a = '0;
				row_a = ROW_W'(row_q + 1'b1);
				m_a   = mod6_inc(m6_q);
			end
			CH_VT: begin
				row_a = ROW_W'(row_q + ROW_W'(VT_STEP) - ROW_W'(m6_q));
				m_a   = '0;
			end
			CH_FF: begin
				is_ff = 1'b1;
				col_a = '0;
				row_a = '0;
				m_a   = '0;
			end
			CH_CR: begin
				col_a = '0;
			end
			default: begin
				if (char_q >= PRINT_MIN && char_q != CH_DEL) begin
					exec_we   = 1'b1;
					exec_data = {attr_q, char_q};
					col_a     = COL_W'(col_q + 1'b1);
				end
			end
		endcase

		if (col_a >= COL_W'(COLUMNS)) begin
			col_f = '0;
			row_f = ROW_W'(row_a + 1'b1);
			m_f   = mod6_inc(m_a);
		end else begin
			col_f = col_a;
			row_f = row_a;
			m_f   = m_a;
		end
		scroll_need = (row_f >= ROW_W'(ROWS));
		excess_f    = MOD6_W'(row_f - ROW_W'(ROWS - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (fill_last) begin
					state_d = boot_q ? ST_IDLE : ST_LOC;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_READ) begin
					state_d = ST_FINISH;
				end else if (is_ff) begin
					state_d = ST_FILL;
				end else if (scroll_need) begin
					state_d = ST_SCRL_SET;
				end else begin
					state_d = ST_LOC;
				end
			end
			ST_SCRL_SET: state_d = ST_COPY;
			ST_COPY: begin
				if (cnt_q == last_q) begin
					state_d = ST_FILL;
				end
			end
			ST_LOC: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A pending copy write always wins the write port; the fill holds its count for it.
	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = blank;
		ram_raddr = AW'(cnt_q + off_q);
		if (wr_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata;
		end
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				ram_raddr = AW'(cmd.cell_index);
			end
			ST_FILL: begin
				if (!wr_pend_s1) begin
					ram_we = 1'b1;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_PUT && exec_we) begin
					ram_we    = 1'b1;
					ram_waddr = exec_addr;
					ram_wdata = exec_data;
				end
			end
			ST_SCRL_SET, ST_COPY, ST_LOC, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			m6_q        <= '0;
			loc_q       <= '0;
			cnt_q       <= '0;
			boot_q      <= 1'b1;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_pend_s1 <= (state_q == ST_COPY);
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (!wr_pend_s1) begin
						cnt_q <= AW'(cnt_q + 1'b1);
					end
					if (fill_last) begin
						boot_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (op_q == OP_PUT) begin
						col_q <= col_f;
						row_q <= scroll_need ? ROW_W'(ROWS - 1) : row_f;
						m6_q  <= scroll_need ? LAST_MOD6 : m_f;
						if (is_ff) begin
							cnt_q <= '0;
						end
					end
				end
				ST_SCRL_SET: cnt_q <= '0;
				ST_COPY: cnt_q <= AW'(cnt_q + 1'b1);
				ST_LOC: loc_q <= AW'(int'(row_q) * COLUMNS + int'(col_q));
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q    <= cmd.operation;
			char_q  <= cmd.char_code;
			rd_ok_q <= (int'(cmd.cell_index) < CELLS);
		end
		if (state_q == ST_EXEC) begin
			cell_q   <= (op_q == OP_READ && rd_ok_q) ? ram_rdata : '0;
			excess_q <= excess_f;
		end
		if (state_q == ST_SCRL_SET) begin
			off_q  <= AW'(int'(excess_q) * COLUMNS);
			last_q <= AW'(CELLS - 1 - int'(excess_q) * COLUMNS);
		end
		wr_addr_s1 <= cnt_q;
		if (out_load) begin
			out_loc_q  <= LOC_W'(loc_q);
			out_cell_q <= cell_q;
			out_echo_q <= (op_q == OP_PUT) ? char_q : '0;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_location = out_loc_q;
	assign rsp.cell_value      = out_cell_q;
	assign rsp.echoed_char     = out_echo_q;

	ttc_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_screen_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ===== rtl/core/ttc_checker.sv =====
// Port-level assertions for the text console and their binding to the top level.
module ttc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [ttc_pkg::LOC_W-1:0]  rsp_cursor_location,
	input logic [ttc_pkg::CELL_W-1:0] rsp_cell_value,
	input logic [ttc_pkg::CHAR_W-1:0] rsp_echoed_char
);
	import ttc_pkg::*;

	// The console works on one request at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("console accepted a request while busy");

	// A result is either a read (no echo) or a put (no cell value).
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_cell_value == '0 || rsp_echoed_char == '0))
		else $error("result carries both a cell value and an echoed character");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("stalled result was dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_cursor_location) && $stable(rsp_cell_value)
			&& $stable(rsp_echoed_char))
		else $error("stalled result changed");

endmodule

bind text_console_teletype ttc_checker u_ttc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_cursor_location(rsp.cursor_location),
	.rsp_cell_value     (rsp.cell_value),
	.rsp_echoed_char    (rsp.echoed_char)
);
